// ----- src/shared_hit_track_dedup_merge_top_defines.svh -----
// ----------------------------------------------------------------------------
// shared hit track dedup merge: assertion macros
// property checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SHARED_HIT_TRACK_DEDUP_MERGE_TOP_DEFINES_SVH
`define SHARED_HIT_TRACK_DEDUP_MERGE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle check: property body is an implication or a plain expression
`define SHTDM_CHK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// next-cycle check: consequent must hold in the cycle after the antecedent
`define SHTDM_CHK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SHTDM_CHK(name, prop, msg)
`define SHTDM_CHK_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- src/shtdm_pkg.sv -----
// ----------------------------------------------------------------------------
// shtdm_pkg
// shared types and constants of the shared hit track dedup merge block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shtdm_pkg;

	localparam int DEF_MAX_TRACKS = 16;
	localparam int DEF_MAX_HITS   = 64;

	localparam int TRACK_W = 4;
	localparam int HIT_W   = 16;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EOE  = 1'b1;

	typedef struct packed {
		logic               kept_collection;
		logic [TRACK_W-1:0] kept_track;
		logic               none_kept;
		logic               last_result;
	} res_t;

	typedef struct packed {
		logic               push;
		logic               fin;
		logic               coll;
		logic [TRACK_W-1:0] track;
	} emit_req_t;

	typedef struct packed {
		logic push_ok;
		logic fin_ok;
	} outq_stat_t;

	typedef struct packed {
		logic done;
		logic dup;
	} pair_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDA,
		S_LATA,
		S_SCAN,
		S_CMP,
		S_DONE
	} scan_state_t;

	typedef enum logic [3:0] {
		Q_IDLE,
		Q_DD_PAIR,
		Q_FETCH_A,
		Q_FETCH_B,
		Q_WAIT,
		Q_MG_OUTER,
		Q_MG_INNER,
		Q_MG_WIN,
		Q_MG_WEND,
		Q_TAIL,
		Q_FINAL
	} seq_state_t;

endpackage

// ----- src/shtdm_in_if.sv -----
// ----------------------------------------------------------------------------
// shtdm_in_if
// hit load / end of event channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shtdm_in_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic                           collection;
	logic [shtdm_pkg::TRACK_W-1:0]  track_number;
	logic [shtdm_pkg::HIT_W-1:0]    hit_id;

	modport source (output valid, action, collection, track_number, hit_id, input ready);
	modport sink (input valid, action, collection, track_number, hit_id, output ready);
endinterface

// ----- src/shtdm_out_if.sv -----
// ----------------------------------------------------------------------------
// shtdm_out_if
// surviving track result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shtdm_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kept_collection;
	logic [shtdm_pkg::TRACK_W-1:0]  kept_track;
	logic                           none_kept;
	logic                           last_result;

	modport source (output valid, kept_collection, kept_track, none_kept, last_result,
		input ready);
	modport sink (input valid, kept_collection, kept_track, none_kept, last_result,
		output ready);
endinterface

// ----- src/shtdm_ram.sv -----
// ----------------------------------------------------------------------------
// shtdm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shtdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/shtdm_scan.sv -----
// ----------------------------------------------------------------------------
// shtdm_scan
// shared hit counter for one track pair, walks the hit store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shared_hit_track_dedup_merge_top_defines.svh"

module shtdm_scan #(
	parameter int MAX_HITS = 64,
	parameter int NSLOT = 32,
	localparam int IW = (NSLOT > 1) ? $clog2(NSLOT) : 1,
	localparam int CW = $clog2(MAX_HITS + 1),
	localparam int AW = (NSLOT * MAX_HITS > 1) ? $clog2(NSLOT * MAX_HITS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [IW-1:0]            a_idx,
	input  logic [IW-1:0]            b_idx,
	input  logic [CW-1:0]            na,
	input  logic [CW-1:0]            nb,
	output logic                     rd_en,
	output logic [AW-1:0]            rd_addr,
	input  logic [shtdm_pkg::HIT_W-1:0] rd_data,
	output shtdm_pkg::pair_rsp_t     rsp
);
	import shtdm_pkg::*;

	scan_state_t st_q, st_d;
	logic [CW-1:0]    k_q, l_q, s_q;
	logic [HIT_W-1:0] h_q;
	logic             hit_match;

	assign hit_match = (rd_data == h_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (start) st_d = S_RDA;
			S_RDA:  st_d = (k_q == na) ? S_DONE : S_LATA;
			S_LATA: st_d = S_SCAN;
			S_SCAN: st_d = (l_q == nb) ? S_RDA : S_CMP;
			S_CMP:  st_d = hit_match ? S_RDA : S_SCAN;
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		rsp.done = 1'b0;
		rsp.dup  = 1'b0;
		unique case (st_q)
			S_RDA: begin
				rd_en   = (k_q != na);
				rd_addr = AW'(int'(a_idx) * MAX_HITS + int'(k_q));
			end
			S_SCAN: begin
				rd_en   = (l_q != nb);
				rd_addr = AW'(int'(b_idx) * MAX_HITS + int'(l_q));
			end
			S_DONE: begin
				rsp.done = 1'b1;
				rsp.dup  = ({s_q, 1'b0} > {1'b0, na}) || ({s_q, 1'b0} > {1'b0, nb});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q  <= '0;
			l_q  <= '0;
			s_q  <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				S_IDLE: if (start) begin
					k_q <= '0;
					s_q <= '0;
				end
				S_LATA: l_q <= '0;
				S_SCAN: if (l_q == nb) k_q <= k_q + 1'b1;
				S_CMP: begin
					if (hit_match) begin
						s_q <= s_q + 1'b1;
						k_q <= k_q + 1'b1;
					end else begin
						l_q <= l_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// hit of the first track held while the second track is walked
	always_ff @(posedge clk) begin
		if (st_q == S_LATA) h_q <= rd_data;
	end

	`SHTDM_CHK(a_k_range, (st_q != S_IDLE) |-> (k_q <= na), "hit index past track a")
	`SHTDM_CHK(a_s_le_k, (s_q <= k_q), "shared count above walked hits")
	`SHTDM_CHK(a_l_range, (st_q == S_CMP) |-> (l_q < nb), "compare past track b")

endmodule

// ----- src/shtdm_outq.sv -----
// ----------------------------------------------------------------------------
// shtdm_outq
// one-deep hold for the last-result mark plus the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shared_hit_track_dedup_merge_top_defines.svh"

module shtdm_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shtdm_pkg::emit_req_t   req,
	output shtdm_pkg::outq_stat_t  stat,
	shtdm_out_if.source            tracks
);
	import shtdm_pkg::*;

	logic pend_v_q, out_v_q;
	res_t pend_q, out_q;
	logic out_free, do_push, do_fin, out_load;

	assign out_free     = !out_v_q || tracks.ready;
	assign stat.push_ok = !pend_v_q || out_free;
	assign stat.fin_ok  = out_free;
	assign do_push      = req.push && stat.push_ok;
	assign do_fin       = req.fin && stat.fin_ok;
	assign out_load     = (do_push && pend_v_q) || do_fin;

	assign tracks.valid           = out_v_q;
	assign tracks.kept_collection = out_q.kept_collection;
	assign tracks.kept_track      = out_q.kept_track;
	assign tracks.none_kept       = out_q.none_kept;
	assign tracks.last_result     = out_q.last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (do_push) pend_v_q <= 1'b1;
			else if (do_fin) pend_v_q <= 1'b0;
			if (out_load) out_v_q <= 1'b1;
			else if (tracks.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			pend_q <= '{kept_collection: req.coll, kept_track: req.track,
				none_kept: 1'b0, last_result: 1'b0};
			if (pend_v_q) out_q <= pend_q;
		end else if (do_fin) begin
			if (pend_v_q) out_q <= '{kept_collection: pend_q.kept_collection,
				kept_track: pend_q.kept_track, none_kept: 1'b0, last_result: 1'b1};
			else out_q <= '{kept_collection: 1'b0, kept_track: '0,
				none_kept: 1'b1, last_result: 1'b1};
		end
	end

	`SHTDM_CHK_NEXT(a_push_held, do_push, pend_v_q, "pushed track not held")
	`SHTDM_CHK_NEXT(a_fin_last, do_fin, out_v_q && out_q.last_result && !pend_v_q,
		"event close did not present last result")
	`SHTDM_CHK(a_none_zero, (out_v_q && out_q.none_kept) |->
		((out_q.kept_track == '0) && !out_q.kept_collection), "empty result not zeroed")

endmodule

// ----- src/shared_hit_track_dedup_merge_top.sv -----
// ----------------------------------------------------------------------------
// shared_hit_track_dedup_merge_top
// loads track hits of two collections, removes shared-hit duplicates and
// merges the collections, emitting the surviving tracks per event
// ----------------------------------------------------------------------------
//  channel | dir | fields                                          | transfer
//  hits    | in  | action, collection, track_number, hit_id        | valid & ready
//  tracks  | out | kept_collection, kept_track, none_kept, last_result | valid & ready
//
//  hit loads stream at one transfer per cycle while the block is idle
//  end of event runs the pair search over the hit store ram: per checked
//  pair each hit of a is read and compared against the hits of b until a
//  match; pairs bounded by both in-collection triangles plus n0*n1 merge
//  pairs
//  hits is not ready from the end of event transfer until the final result
//  is handed to the output register; tracks stalls hold the merge in place
//  arst_n clears counts, totals and flags; the hit store needs no clearing,
//  only entries below a track's count are ever read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shared_hit_track_dedup_merge_top_defines.svh"

module shared_hit_track_dedup_merge_top #(
	parameter int MAX_TRACKS = shtdm_pkg::DEF_MAX_TRACKS,
	parameter int MAX_HITS   = shtdm_pkg::DEF_MAX_HITS
) (
	input  logic         clk,
	input  logic         arst_n,
	shtdm_in_if.sink     hits,
	shtdm_out_if.source  tracks
);
	import shtdm_pkg::*;

	// only the first sixteen slots of a collection are addressable
	localparam int SLOTS = (MAX_TRACKS < 16) ? MAX_TRACKS : 16;
	localparam int NSLOT = 2 * SLOTS;
	localparam int IW    = $clog2(NSLOT);
	localparam int CW    = $clog2(MAX_HITS + 1);
	localparam int JW    = $clog2(SLOTS + 2);
	localparam int TW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DEPTH = NSLOT * MAX_HITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	seq_state_t state_q, state_d;

	// per-event bookkeeping
	logic [CW-1:0]    cnt_q [NSLOT];
	logic [JW-1:0]    tot_q [2];
	logic [NSLOT-1:0] skip_q;
	logic [NSLOT-1:0] keep_q;
	logic [SLOTS-1:0] emitted_q;

	// loop indices: i walks first tracks, j second tracks
	logic [JW-1:0] i_q, j_q;
	logic          c_q;
	logic          mg_q;
	logic [CW-1:0] na_q, nb_q;

	logic [IW-1:0] a_idx, b_idx, ld_idx, cnt_rd_idx;
	logic [CW-1:0] cnt_rd;
	logic [JW-1:0] n_dd, n0, n1, t_plus1;
	logic [TW-1:0] jt;
	logic          hits_xfer, is_load, is_eoe, ld_ok, ram_we, win, tail_emit;
	logic          scan_start;

	logic                rd_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [HIT_W-1:0]    rd_data;
	pair_rsp_t           rsp;
	emit_req_t           req;
	outq_stat_t          stat;

	assign hits_xfer = hits.valid && hits.ready;
	assign is_load   = hits_xfer && (hits.action == ACT_LOAD);
	assign is_eoe    = hits_xfer && (hits.action == ACT_EOE);
	assign ld_ok     = (int'(hits.track_number) < SLOTS);
	assign ld_idx    = IW'(int'(hits.collection) * SLOTS + int'(hits.track_number));
	assign t_plus1   = JW'({1'b0, hits.track_number} + 5'd1);

	assign a_idx = IW'(int'(mg_q ? 1'b0 : c_q) * SLOTS + int'(i_q));
	assign b_idx = IW'(int'(mg_q ? 1'b1 : c_q) * SLOTS + int'(j_q));
	assign jt    = j_q[TW-1:0];

	assign n_dd = tot_q[c_q];
	assign n0   = tot_q[0];
	assign n1   = tot_q[1];

	// single read point into the count array
	always_comb begin
		unique case (state_q)
			Q_IDLE:    cnt_rd_idx = ld_idx;
			Q_FETCH_A: cnt_rd_idx = a_idx;
			default:   cnt_rd_idx = b_idx;
		endcase
	end
	assign cnt_rd = cnt_q[cnt_rd_idx];

	// stored hit goes at the track's fill level; full tracks drop hits
	assign ram_we  = is_load && ld_ok && (cnt_rd < CW'(MAX_HITS));
	assign wr_addr = AW'(int'(ld_idx) * MAX_HITS + int'(cnt_rd));

	// track b beats track a (shared hits and strictly longer) and ends a's walk
	assign win       = rsp.dup && (nb_q > na_q);
	assign tail_emit = keep_q[b_idx] && !skip_q[b_idx] && !emitted_q[jt];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			Q_IDLE: if (is_eoe) state_d = Q_DD_PAIR;
			Q_DD_PAIR: begin
				if (i_q >= n_dd) begin
					if (c_q) state_d = Q_MG_OUTER;
				end else if (j_q < n_dd) begin
					state_d = Q_FETCH_A;
				end
			end
			Q_FETCH_A: state_d = Q_FETCH_B;
			Q_FETCH_B: state_d = Q_WAIT;
			Q_WAIT: begin
				if (rsp.done) begin
					if (!mg_q) state_d = Q_DD_PAIR;
					else state_d = win ? Q_MG_WIN : Q_MG_INNER;
				end
			end
			Q_MG_OUTER: begin
				if (i_q >= n0) state_d = Q_TAIL;
				else if (!skip_q[a_idx]) state_d = Q_MG_INNER;
			end
			Q_MG_INNER: begin
				if (j_q >= n1) state_d = Q_MG_WEND;
				else if (!skip_q[b_idx]) state_d = Q_FETCH_A;
			end
			Q_MG_WIN: if (emitted_q[jt] || stat.push_ok) state_d = Q_MG_WEND;
			Q_MG_WEND: if (!keep_q[a_idx] || stat.push_ok) state_d = Q_MG_OUTER;
			Q_TAIL: if (j_q >= n1) state_d = Q_FINAL;
			Q_FINAL: if (stat.fin_ok) state_d = Q_IDLE;
			default: state_d = Q_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		hits.ready = 1'b0;
		scan_start = 1'b0;
		req.push   = 1'b0;
		req.fin    = 1'b0;
		req.coll   = 1'b1;
		req.track  = TRACK_W'(j_q);
		unique case (state_q)
			Q_IDLE:    hits.ready = 1'b1;
			Q_FETCH_B: scan_start = 1'b1;
			Q_MG_WIN:  req.push = !emitted_q[jt];
			Q_MG_WEND: begin
				req.push  = keep_q[a_idx];
				req.coll  = 1'b0;
				req.track = TRACK_W'(i_q);
			end
			Q_TAIL:    req.push = (j_q < n1) && tail_emit;
			Q_FINAL:   req.fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= Q_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			c_q       <= 1'b0;
			mg_q      <= 1'b0;
			tot_q[0]  <= '0;
			tot_q[1]  <= '0;
			skip_q    <= '0;
			keep_q    <= '1;
			emitted_q <= '0;
			for (int s = 0; s < NSLOT; s++) cnt_q[s] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				Q_IDLE: begin
					if (is_load && ld_ok) begin
						if (ram_we) cnt_q[ld_idx] <= cnt_rd + 1'b1;
						if (tot_q[hits.collection] < t_plus1) tot_q[hits.collection] <= t_plus1;
					end else if (is_eoe) begin
						c_q  <= 1'b0;
						mg_q <= 1'b0;
						i_q  <= '0;
						j_q  <= JW'(1);
					end
				end
				Q_DD_PAIR: begin
					if (i_q >= n_dd) begin
						i_q <= '0;
						if (!c_q) begin
							c_q <= 1'b1;
							j_q <= JW'(1);
						end else begin
							mg_q <= 1'b1;
						end
					end else if (j_q >= n_dd) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + JW'(2);
					end
				end
				Q_WAIT: begin
					if (rsp.done) begin
						if (!mg_q) begin
							// inside one collection the longer track survives
							if (win) begin
								skip_q[a_idx] <= 1'b1;
								i_q <= i_q + 1'b1;
								j_q <= i_q + JW'(2);
							end else begin
								if (rsp.dup) skip_q[b_idx] <= 1'b1;
								j_q <= j_q + 1'b1;
							end
						end else if (!win) begin
							if (rsp.dup) keep_q[b_idx] <= 1'b0;
							j_q <= j_q + 1'b1;
						end
					end
				end
				Q_MG_OUTER: begin
					if (i_q >= n0) j_q <= '0;
					else if (skip_q[a_idx]) i_q <= i_q + 1'b1;
					else j_q <= '0;
				end
				Q_MG_INNER: if (j_q < n1 && skip_q[b_idx]) j_q <= j_q + 1'b1;
				Q_MG_WIN: begin
					if (emitted_q[jt] || stat.push_ok) begin
						emitted_q[jt] <= 1'b1;
						keep_q[a_idx] <= 1'b0;
						keep_q[b_idx] <= 1'b0;
					end
				end
				Q_MG_WEND: if (!keep_q[a_idx] || stat.push_ok) i_q <= i_q + 1'b1;
				Q_TAIL: if (j_q < n1 && (!tail_emit || stat.push_ok)) j_q <= j_q + 1'b1;
				Q_FINAL: begin
					// event closed: counts, totals and flags back to reset values for the next event
					if (stat.fin_ok) begin
						mg_q      <= 1'b0;
						tot_q[0]  <= '0;
						tot_q[1]  <= '0;
						skip_q    <= '0;
						keep_q    <= '1;
						emitted_q <= '0;
						for (int s = 0; s < NSLOT; s++) cnt_q[s] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// hit counts of the pair under test
	always_ff @(posedge clk) begin
		if (state_q == Q_FETCH_A) na_q <= cnt_rd;
		if (state_q == Q_FETCH_B) nb_q <= cnt_rd;
	end

	shtdm_ram #(
		.WIDTH (HIT_W),
		.DEPTH (DEPTH)
	) u_hit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (hits.hit_id),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	shtdm_scan #(
		.MAX_HITS (MAX_HITS),
		.NSLOT    (NSLOT)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.a_idx   (a_idx),
		.b_idx   (b_idx),
		.na      (na_q),
		.nb      (nb_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (rsp)
	);

	shtdm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.tracks (tracks)
	);

	`SHTDM_CHK(a_dd_order, (state_q == Q_WAIT && !mg_q) |-> (j_q > i_q),
		"in-collection pair out of order")
	`SHTDM_CHK(a_pair_range, (state_q == Q_WAIT) |->
		((i_q < (mg_q ? n0 : n_dd)) && (j_q < (mg_q ? n1 : n_dd))), "pair outside totals")
	`SHTDM_CHK_NEXT(a_clear, (state_q == Q_FINAL && stat.fin_ok),
		(tot_q[0] == '0) && (tot_q[1] == '0) && (skip_q == '0), "event state not cleared")

endmodule

// ----- sim/tb_shared_hit_track_dedup_merge_top.sv -----
// ----------------------------------------------------------------------------
// tb_shared_hit_track_dedup_merge_top
// loads random and directed hit sets for two track collections, predicts the
// surviving tracks of each event and compares every track transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shared_hit_track_dedup_merge_top;
	import shtdm_pkg::*;

	localparam int NTRK = DEF_MAX_TRACKS;
	localparam int NHIT = DEF_MAX_HITS;
	localparam int SLOT_LIM = (NTRK < 16) ? NTRK : 16;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic               action;
		logic               collection;
		logic [TRACK_W-1:0] track_number;
		logic [HIT_W-1:0]   hit_id;
	} hit_item_t;

	logic clk;
	logic arst_n;

	shtdm_in_if  hits();
	shtdm_out_if tracks();

	shared_hit_track_dedup_merge_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.hits   (hits),
		.tracks (tracks)
	);

	// predictor state: copy of the per-event track store
	logic [HIT_W-1:0] pred_hits [2*NTRK][NHIT];
	int               pred_cnt  [2*NTRK];
	int               pred_total[2];
	bit               pred_skip [2*NTRK];
	bit               pred_keep [2*NTRK];

	hit_item_t pending_items[$];
	res_t      survivors_due[$];

	int  errors;
	int  cycles;
	int  n_queued;
	bit  in_taken;
	bit  hold_off_req;
	int  hold_off_left;
	bit  no_idle;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void clear_event();
		for (int i = 0; i < 2*NTRK; i++) begin
			pred_cnt[i]  = 0;
			pred_skip[i] = 0;
			pred_keep[i] = 1;
		end
		pred_total[0] = 0;
		pred_total[1] = 0;
	endfunction

	function automatic int shared_count(int a, int b);
		int n;
		n = 0;
		for (int k = 0; k < pred_cnt[a]; k++)
			for (int l = 0; l < pred_cnt[b]; l++)
				if (pred_hits[b][l] == pred_hits[a][k]) begin
					n++;
					break;
				end
		return n;
	endfunction

	function automatic bit tracks_overlap(int a, int b);
		int s;
		s = shared_count(a, b);
		return (2*s > pred_cnt[a]) || (2*s > pred_cnt[b]);
	endfunction

	function automatic void push_survivor(bit c, int t);
		res_t r;
		r = '0;
		r.kept_collection = c;
		r.kept_track = t[TRACK_W-1:0];
		survivors_due = {survivors_due, r};
	endfunction

	function automatic void queue_item(hit_item_t it);
		pending_items = {pending_items, it};
		n_queued++;
	endfunction

	// applies one accepted hit transfer to the predicted event
	function automatic void predict_survivors(hit_item_t it);
		int c, t, slot, n0, n1, nres;
		bit emitted [NTRK];
		c = int'(it.collection);
		t = int'(it.track_number);
		if (it.action == ACT_LOAD) begin
			if (t >= SLOT_LIM)
				return;
			slot = c*NTRK + t;
			if (pred_cnt[slot] < NHIT) begin
				pred_hits[slot][pred_cnt[slot]] = it.hit_id;
				pred_cnt[slot]++;
			end
			if (pred_total[c] < t+1)
				pred_total[c] = t+1;
			return;
		end
		// in-collection duplicate marking
		for (int cc = 0; cc < 2; cc++)
			for (int i = 0; i < pred_total[cc]; i++)
				for (int j = i+1; j < pred_total[cc]; j++)
					if (tracks_overlap(cc*NTRK+i, cc*NTRK+j)) begin
						if (pred_cnt[cc*NTRK+j] > pred_cnt[cc*NTRK+i]) begin
							pred_skip[cc*NTRK+i] = 1;
							break;
						end
						pred_skip[cc*NTRK+j] = 1;
					end
		for (int i = 0; i < NTRK; i++)
			emitted[i] = 0;
		n0 = pred_total[0];
		n1 = pred_total[1];
		nres = survivors_due.size();
		for (int i1 = 0; i1 < n0; i1++) begin
			if (pred_skip[i1])
				continue;
			for (int i2 = 0; i2 < n1; i2++) begin
				if (pred_skip[NTRK+i2])
					continue;
				if (tracks_overlap(i1, NTRK+i2)) begin
					if (pred_cnt[NTRK+i2] > pred_cnt[i1]) begin
						if (!emitted[i2]) begin
							push_survivor(1'b1, i2);
							emitted[i2] = 1;
						end
						pred_keep[i1] = 0;
						pred_keep[NTRK+i2] = 0;
						break;
					end
					pred_keep[NTRK+i2] = 0;
				end
			end
			if (pred_keep[i1])
				push_survivor(1'b0, i1);
		end
		for (int i2 = 0; i2 < n1; i2++)
			if (pred_keep[NTRK+i2] && !pred_skip[NTRK+i2] && !emitted[i2])
				push_survivor(1'b1, i2);
		if (survivors_due.size() == nres) begin
			res_t r;
			r = '0;
			r.none_kept = 1;
			r.last_result = 1;
			survivors_due = {survivors_due, r};
		end else begin
			survivors_due[survivors_due.size()-1].last_result = 1;
		end
		clear_event();
	endfunction

	function automatic hit_item_t mk_item(bit act, bit c, int t, int h);
		hit_item_t it;
		it.action = act;
		it.collection = c;
		it.track_number = t[TRACK_W-1:0];
		it.hit_id = h[HIT_W-1:0];
		return it;
	endfunction

	task automatic add_track(bit c, int t, int base, int n);
		for (int k = 0; k < n; k++)
			queue_item(mk_item(ACT_LOAD, c, t, base + k));
	endtask

	// random event: tracks built from a small hit pool so overlaps are common
	task automatic add_random_event(int budget);
		int pool, nt, n;
		pool = int'($urandom_range(4, 40)) * 16;
		nt = int'($urandom_range(0, 6));
		for (int i = 0; i < nt && budget > 0; i++) begin
			bit c;
			int t, base;
			c = 1'($urandom);
			t = int'($urandom_range(0, 15));
			base = int'($urandom_range(0, 65535 - pool));
			n = int'($urandom_range(1, 9));
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 3) == 0)
					queue_item(mk_item(ACT_LOAD, c, t, int'($urandom)));
				else
					queue_item(mk_item(ACT_LOAD, c, t,
						base + int'($urandom_range(0, 12))));
				budget--;
			end
		end
		queue_item(mk_item(ACT_EOE, 1'($urandom), int'($urandom), int'($urandom)));
	endtask

	// driver: presents items at the falling edge, holds an offer until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hits.valid || in_taken) begin
				if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 21)) begin
					hit_item_t it;
					it = pending_items[0];
					hits.valid        <= 1'b1;
					hits.action       <= it.action;
					hits.collection   <= it.collection;
					hits.track_number <= it.track_number;
					hits.hit_id       <= it.hit_id;
				end else begin
					hits.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long hold-off or random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_req) begin
				hold_off_req  = 0;
				hold_off_left = 400;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				tracks.ready <= 1'b0;
			end else begin
				tracks.ready <= no_idle || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	// monitor: samples transfers at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			in_taken = hits.valid && hits.ready;
			if (in_taken)
				predict_survivors(pending_items.pop_front());
			if (tracks.valid && tracks.ready) begin
				res_t got;
				got.kept_collection = tracks.kept_collection;
				got.kept_track      = tracks.kept_track;
				got.none_kept       = tracks.none_kept;
				got.last_result     = tracks.last_result;
				if (survivors_due.size() == 0) begin
					$display("%0t: unexpected track transfer expected none actual %p",
						$realtime, got);
					errors++;
				end else begin
					res_t exp_r;
					exp_r = survivors_due.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p",
							$realtime, exp_r, got);
						errors++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int drained;
		errors = 0;
		cycles = 0;
		n_queued = 0;
		in_taken = 0;
		hold_off_req = 0;
		hold_off_left = 0;
		no_idle = 0;
		clear_event();
		arst_n = 1'b0;
		hits.valid = 1'b0;
		hits.action = ACT_LOAD;
		hits.collection = 1'b0;
		hits.track_number = '0;
		hits.hit_id = '0;
		tracks.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// empty event
		queue_item(mk_item(ACT_EOE, 1'b0, 0, 0));
		// extreme ids, slot 15, gap slots, longer collection-1 track wins
		queue_item(mk_item(ACT_LOAD, 1'b0, 15, 32'hFFFF));
		queue_item(mk_item(ACT_LOAD, 1'b0, 15, 0));
		add_track(1'b0, 0, 100, 3);
		add_track(1'b1, 0, 100, 5);
		add_track(1'b1, 3, 100, 3);
		add_track(1'b0, 2, 500, 4);
		add_track(1'b0, 4, 500, 2);
		queue_item(mk_item(ACT_EOE, 1'b1, 15, 32'hFFFF));
		// full track: overflow hits dropped
		add_track(1'b1, 7, 1000, NHIT + 4);
		add_track(1'b0, 7, 1000 + NHIT, 3);
		queue_item(mk_item(ACT_EOE, 1'b0, 0, 0));

		// random events, long hold-off early so the block stalls its input
		for (int e = 0; n_queued < 300; e++) begin
			add_random_event(12);
			if (e == 4) begin
				wait (pending_items.size() < 40);
				hold_off_req = 1;
			end
			if (e == 8)
				no_idle = 1;
			if (e == 14)
				no_idle = 0;
			wait (pending_items.size() < 60);
		end
		wait (pending_items.size() == 0);
		drained = 0;
		while (survivors_due.size() != 0 && drained < 200000) begin
			@(posedge clk);
			drained++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && survivors_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
